// ===== rtl/gmop_pkg.sv =====
`timescale 1ns / 1ps

package gmop_pkg;

    // Query vertices the stores hold; masks are 32 bits, so at most 32 take part in a plan.
    localparam int MAX_QUERY_VERTICES = 32;
    localparam int VLIM   = (MAX_QUERY_VERTICES < 32) ? MAX_QUERY_VERTICES : 32;
    localparam int ADDR_W = $clog2(MAX_QUERY_VERTICES);
    localparam int VW     = 5;     // vertex number width
    localparam int CW     = 6;     // vertex count width
    localparam int DW     = 32;    // candidate count and mask width
    localparam int DEG_W  = 6;     // popcount of a 32-bit mask

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PLAN = 1'b1;

    typedef enum logic [0:0] {
        REG_VERTEX_COUNT      = 1'b0,
        REG_DATA_VERTEX_COUNT = 1'b1
    } reg_index_t;

endpackage

// ===== rtl/gmop_ram.sv =====
`timescale 1ns / 1ps

module gmop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/greedy_match_order_planner_core.sv =====
`timescale 1ns / 1ps

// Greedy matching-order planner. A load request (cmd=0) writes one query vertex's candidate
// count and neighbor mask and never raises busy, so loads can stream one per clock while the
// planner is idle. A plan request (cmd=1) raises busy until the last result has been issued.
// Each position scans the vertex store through its single read port and commits the winner;
// after the first position it then searches the earlier positions in order for the pivot
// (order store read, then vertex store read, then test) until one is linked or none remain, and then issues
// the result. Once the query proves disconnected the remaining positions come out one per
// cycle. Results appear on result_valid for exactly one cycle each and cannot be held off.
// Configuration must only be written while idle.
module greedy_match_order_planner_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [gmop_pkg::VW-1:0]      vertex_index,
    input  logic [gmop_pkg::DW-1:0]      candidate_count,
    input  logic [gmop_pkg::DW-1:0]      neighbor_mask,
    input  logic                         cfg_write_en,
    input  logic [0:0]                   cfg_index,
    input  logic [gmop_pkg::DW-1:0]      cfg_data,
    output logic                         result_valid,
    output logic [gmop_pkg::VW-1:0]      position,
    output logic [gmop_pkg::VW-1:0]      order_vertex,
    output logic [gmop_pkg::VW-1:0]      pivot_node,
    output logic                         pivot_found,
    output logic                         disconnected,
    output logic                         last
);

    import gmop_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_COMMIT,
        ST_PIV_ORD,
        ST_PIV_ADJ,
        ST_PIV_TEST,
        ST_EMIT
    } state_t;

    function automatic logic [DEG_W-1:0] pop32(input logic [DW-1:0] x);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int k = 0; k < 16; k++) l1[k] = {1'b0, x[2*k]} + {1'b0, x[2*k+1]};
        for (int k = 0; k < 8; k++)  l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
        for (int k = 0; k < 4; k++)  l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
        for (int k = 0; k < 2; k++)  l4[k] = {1'b0, l3[2*k]} + {1'b0, l3[2*k+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    state_t            state_reg;
    logic              failed_reg;
    logic [CW-1:0]     vcount_reg;
    logic [DW-1:0]     dvc_reg;
    logic [CW-1:0]     n_reg;
    logic [DW-1:0]     m_reg;
    logic [DW-1:0]     visited_reg;
    logic [DW-1:0]     frontier_reg;
    logic [VW-1:0]     pos_reg;
    logic [CW-1:0]     v_reg;
    logic [VW-1:0]     j_reg;
    logic [VW-1:0]     u_reg;
    logic              rd_vld_reg;
    logic [VW-1:0]     rd_idx_reg;
    logic              have_reg;
    logic [VW-1:0]     best_v_reg;
    logic [DW-1:0]     best_cand_reg;
    logic [DEG_W-1:0]  best_deg_reg;
    logic [DW-1:0]     best_adj_reg;
    logic [VW-1:0]     piv_v_reg;
    logic              piv_found_reg;

    logic              result_valid_reg;
    logic [VW-1:0]     position_reg;
    logic [VW-1:0]     order_vertex_reg;
    logic [VW-1:0]     pivot_node_reg;
    logic              pivot_found_reg;
    logic              disconnected_reg;
    logic              last_reg;

    logic              load_we;
    logic [ADDR_W-1:0] vram_raddr;
    logic [2*DW-1:0]   vram_rdata;
    logic              oram_we;
    logic [VW-1:0]     oram_rdata;

    logic [DW-1:0]     cand_v;
    logic [DW-1:0]     adj_v;
    logic [DEG_W-1:0]  deg_v;
    logic              eligible;
    logic              better;
    logic              take;
    logic              linked;
    logic              is_last;
    logic [CW-1:0]     n_sat;
    logic [DW-1:0]     m_sat;

    assign load_we = start && !busy && (cmd == CMD_LOAD)
                     && (int'(vertex_index) < MAX_QUERY_VERTICES);

    always_comb
    begin
        vram_raddr = ADDR_W'(v_reg[VW-1:0]);
        if (state_reg == ST_PIV_ADJ)
        begin
            vram_raddr = ADDR_W'(oram_rdata);
        end
    end

    gmop_ram #(
        .WIDTH(2 * DW),
        .DEPTH(MAX_QUERY_VERTICES)
    ) u_vertex_ram (
        .clk  (clk),
        .we   (load_we),
        .waddr(ADDR_W'(vertex_index)),
        .wdata({neighbor_mask, candidate_count}),
        .raddr(vram_raddr),
        .rdata(vram_rdata)
    );

    assign oram_we = (state_reg == ST_COMMIT) && have_reg;

    gmop_ram #(
        .WIDTH(VW),
        .DEPTH(VLIM)
    ) u_order_ram (
        .clk  (clk),
        .we   (oram_we),
        .waddr($clog2(VLIM)'(pos_reg)),
        .wdata(best_v_reg),
        .raddr($clog2(VLIM)'(j_reg)),
        .rdata(oram_rdata)
    );

    // Effective vertex count saturated into 2..VLIM, and its bit mask.
    always_comb
    begin
        n_sat = vcount_reg;
        if (vcount_reg < CW'(2))
        begin
            n_sat = CW'(2);
        end
        else if (int'(vcount_reg) > VLIM)
        begin
            n_sat = CW'(VLIM);
        end
        m_sat = DW'((33'(1) << n_sat) - 33'(1));
    end

    assign cand_v   = vram_rdata[DW-1:0];
    assign adj_v    = vram_rdata[2*DW-1:DW] & m_reg;
    assign deg_v    = pop32(adj_v);
    // Start vertex is chosen among all vertices, later ones from the unvisited frontier within the data vertex count.
    assign eligible = (pos_reg == '0)
                      || (frontier_reg[rd_idx_reg] && !visited_reg[rd_idx_reg]
                          && (cand_v <= dvc_reg));
    assign better   = (cand_v < best_cand_reg)
                      || ((cand_v == best_cand_reg) && (deg_v > best_deg_reg));
    assign take     = rd_vld_reg && eligible && (!have_reg || better);
    assign linked   = best_adj_reg[u_reg] || adj_v[best_v_reg];
    assign is_last  = ({1'b0, pos_reg} == (n_reg - CW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            failed_reg       <= 1'b0;
            vcount_reg       <= CW'(2);
            dvc_reg          <= '1;
            visited_reg      <= '0;
            frontier_reg     <= '0;
            have_reg         <= 1'b0;
            rd_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            rd_vld_reg       <= 1'b0;

            if (cfg_write_en)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_VERTEX_COUNT:      vcount_reg <= cfg_data[CW-1:0];
                    REG_DATA_VERTEX_COUNT: dvc_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (take)
            begin
                have_reg      <= 1'b1;
                best_v_reg    <= rd_idx_reg;
                best_cand_reg <= cand_v;
                best_deg_reg  <= deg_v;
                best_adj_reg  <= adj_v;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && (cmd == CMD_PLAN))
                    begin
                        n_reg        <= n_sat;
                        m_reg        <= m_sat;
                        visited_reg  <= '0;
                        frontier_reg <= '0;
                        pos_reg      <= '0;
                        v_reg        <= '0;
                        have_reg     <= 1'b0;
                        failed_reg   <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_vld_reg <= 1'b1;
                    rd_idx_reg <= v_reg[VW-1:0];
                    if (v_reg == n_reg - CW'(1))
                    begin
                        state_reg <= ST_SCAN_END;
                    end
                    else
                    begin
                        v_reg <= v_reg + CW'(1);
                    end
                end
                ST_SCAN_END:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (!have_reg)
                    begin
                        failed_reg <= 1'b1;
                        state_reg  <= ST_EMIT;
                    end
                    else
                    begin
                        visited_reg   <= visited_reg | (DW'(1) << best_v_reg);
                        frontier_reg  <= frontier_reg | best_adj_reg;
                        piv_v_reg     <= '0;
                        piv_found_reg <= 1'b0;
                        j_reg         <= '0;
                        state_reg     <= (pos_reg == '0) ? ST_EMIT : ST_PIV_ORD;
                    end
                end
                ST_PIV_ORD:
                begin
                    state_reg <= ST_PIV_ADJ;
                end
                ST_PIV_ADJ:
                begin
                    u_reg     <= oram_rdata;
                    state_reg <= ST_PIV_TEST;
                end
                ST_PIV_TEST:
                begin
                    if (linked)
                    begin
                        piv_v_reg     <= u_reg;
                        piv_found_reg <= 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                    else if ((CW'(j_reg) + CW'(1)) == CW'(pos_reg))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + VW'(1);
                        state_reg <= ST_PIV_ORD;
                    end
                end
                ST_EMIT:
                begin
                    // After a disconnect every remaining position issues here, one per cycle.
                    result_valid_reg <= 1'b1;
                    position_reg     <= pos_reg;
                    last_reg         <= is_last;
                    disconnected_reg <= failed_reg;
                    order_vertex_reg <= failed_reg ? '0 : best_v_reg;
                    pivot_node_reg   <= failed_reg ? '0 : piv_v_reg;
                    pivot_found_reg  <= failed_reg ? 1'b0 : piv_found_reg;
                    if (is_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg  <= pos_reg + VW'(1);
                        v_reg    <= '0;
                        have_reg <= 1'b0;
                        if (!failed_reg)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign order_vertex = order_vertex_reg;
    assign pivot_node   = pivot_node_reg;
    assign pivot_found  = pivot_found_reg;
    assign disconnected = disconnected_reg;
    assign last         = last_reg;

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("busy still high after the final result");

    a_first_no_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (position == '0) |-> !pivot_found)
        else $error("pivot reported at position 0");

    a_disc_streams: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && disconnected && !last |=> result_valid && disconnected)
        else $error("disconnected tail did not continue");

    a_plan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == CMD_PLAN) |=> busy && !result_valid)
        else $error("plan request did not start the sequencer");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import gmop_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_CYCLES = 4;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic        cmd;
        logic [4:0]  vidx;
        logic [31:0] cand;
        logic [31:0] nbr;
        reg_index_t  reg_sel;
        logic [31:0] reg_val;
        int          gap_pct;
    } step_t;

    typedef struct {
        logic [4:0] pos;
        logic [4:0] vtx;
        logic [4:0] piv;
        logic       piv_found;
        logic       disc;
        logic       is_last;
    } order_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_LOAD;
    logic [4:0]  vertex_index = '0;
    logic [31:0] candidate_count = '0;
    logic [31:0] neighbor_mask = '0;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        result_valid;
    logic [4:0]  position;
    logic [4:0]  order_vertex;
    logic [4:0]  pivot_node;
    logic        pivot_found;
    logic        disconnected;
    logic        last;

    step_t          pending[$];
    order_entry_t   order_expect[$];

    // predictor state
    logic [31:0] cand_mem[32];
    logic [31:0] nbr_mem[32];
    logic [5:0]  vc_reg = 6'd2;
    logic [31:0] dvc_reg = 32'hFFFF_FFFF;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int cycle_count = 0;

    // stimulus generator state
    int gen_pct = 19;
    int gen_n = 2;
    int stim_items = 0;

    greedy_match_order_planner_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .vertex_index   (vertex_index),
        .candidate_count(candidate_count),
        .neighbor_mask  (neighbor_mask),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .position       (position),
        .order_vertex   (order_vertex),
        .pivot_node     (pivot_node),
        .pivot_found    (pivot_found),
        .disconnected   (disconnected),
        .last           (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want, int pos);
        if (got != want)
            report_mismatch($sformatf("pos %0d %s got %0d want %0d", pos, name, got, want));
    endtask

    function automatic bit fewer_first(int v, int b, logic [31:0] m);
        if (cand_mem[v] < cand_mem[b])
            return 1'b1;
        return cand_mem[v] == cand_mem[b] &&
            $countones(nbr_mem[v] & m) > $countones(nbr_mem[b] & m);
    endfunction

    function automatic bit adjacent(int a, int b, logic [31:0] m);
        logic [31:0] ma;
        logic [31:0] mb;
        ma = nbr_mem[a] & m;
        mb = nbr_mem[b] & m;
        return ma[b] || mb[a];
    endfunction

    // Greedy order for the current store contents; one entry per position.
    task automatic predict_order();
        int           n;
        int           pick;
        bit           have;
        bit           failed;
        logic [31:0]  m;
        logic [31:0]  seen;
        logic [31:0]  reach;
        logic [63:0]  wide;
        int           placed[32];
        order_entry_t e;
        n = vc_reg;
        if (n < 2) n = 2;
        if (n > 32) n = 32;
        wide = (64'd1 << n) - 64'd1;
        m = wide[31:0];
        seen = '0;
        reach = '0;
        failed = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            pick = 0;
            have = 1'b0;
            if (!failed)
            begin
                if (i == 0)
                begin
                    have = 1'b1;
                    for (int v = 1; v < n; v++)
                        if (fewer_first(v, pick, m)) pick = v;
                end
                else
                begin
                    for (int v = 0; v < n; v++)
                        if (!seen[v] && reach[v] && cand_mem[v] <= dvc_reg)
                            if (!have || fewer_first(v, pick, m))
                            begin
                                pick = v;
                                have = 1'b1;
                            end
                end
                if (!have) failed = 1'b1;
            end
            e.pos = i[4:0];
            e.is_last = (i == n - 1);
            e.vtx = '0;
            e.piv = '0;
            e.piv_found = 1'b0;
            e.disc = failed;
            placed[i] = 0;
            if (!failed)
            begin
                placed[i] = pick;
                seen[pick] = 1'b1;
                reach |= nbr_mem[pick] & m;
                e.vtx = pick[4:0];
                for (int j = 0; j < i && !e.piv_found; j++)
                    if (adjacent(pick, placed[j], m))
                    begin
                        e.piv = placed[j][4:0];
                        e.piv_found = 1'b1;
                    end
            end
            order_expect.insert(order_expect.size(), e);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        step_t head;
        logic  nxt_start;
        logic  nxt_we;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_write_en <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (cmd == CMD_PLAN)
                    predict_order();
                else
                begin
                    cand_mem[vertex_index] = candidate_count;
                    nbr_mem[vertex_index] = neighbor_mask;
                end
            end
            if (order_expect.size() == 0 && !busy && !start && !cfg_write_en)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            nxt_start = start && busy;
            nxt_we = 1'b0;
            if (!nxt_start && pending.size() > 0)
            begin
                head = pending[0];
                case (head.kind)
                    STEP_REQ:
                        if ($urandom_range(99) >= head.gap_pct)
                        begin
                            void'(pending.pop_front());
                            nxt_start = 1'b1;
                            cmd <= head.cmd;
                            vertex_index <= head.vidx;
                            candidate_count <= head.cand;
                            neighbor_mask <= head.nbr;
                        end
                    STEP_CFG:
                        if (quiet_cycles >= QUIET_CYCLES)
                        begin
                            void'(pending.pop_front());
                            nxt_we = 1'b1;
                            cfg_index <= head.reg_sel;
                            cfg_data <= head.reg_val;
                            if (head.reg_sel == REG_VERTEX_COUNT)
                                vc_reg = head.reg_val[5:0];
                            else
                                dvc_reg = head.reg_val;
                        end
                    STEP_DRAIN:
                        if (quiet_cycles >= QUIET_CYCLES)
                            void'(pending.pop_front());
                    default: ;
                endcase
            end
            start <= nxt_start;
            cfg_write_en <= nxt_we;
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch
        order_entry_t want;
        if (rst_n && result_valid)
        begin
            if (order_expect.size() == 0)
                report_mismatch($sformatf("unexpected result at position %0d", position));
            else
            begin
                want = order_expect.pop_front();
                check_field("position", position, want.pos, want.pos);
                check_field("order_vertex", order_vertex, want.vtx, want.pos);
                check_field("pivot_node", pivot_node, want.piv, want.pos);
                check_field("pivot_found", pivot_found, want.piv_found, want.pos);
                check_field("disconnected", disconnected, want.disc, want.pos);
                check_field("last", last, want.is_last, want.pos);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_load(int idx, logic [31:0] cnt, logic [31:0] mask);
        step_t s;
        s.kind = STEP_REQ;
        s.cmd = CMD_LOAD;
        s.vidx = idx[4:0];
        s.cand = cnt;
        s.nbr = mask;
        s.reg_sel = REG_VERTEX_COUNT;
        s.reg_val = '0;
        s.gap_pct = gen_pct;
        pending.insert(pending.size(), s);
        stim_items++;
    endtask

    task automatic push_plan();
        step_t s;
        s.kind = STEP_REQ;
        s.cmd = CMD_PLAN;
        s.vidx = 5'($urandom);
        s.cand = $urandom;
        s.nbr = $urandom;
        s.reg_sel = REG_VERTEX_COUNT;
        s.reg_val = '0;
        s.gap_pct = gen_pct;
        pending.insert(pending.size(), s);
        stim_items++;
    endtask

    task automatic push_cfg(reg_index_t r, logic [31:0] val);
        step_t s;
        s.kind = STEP_CFG;
        s.cmd = CMD_LOAD;
        s.vidx = '0;
        s.cand = '0;
        s.nbr = '0;
        s.reg_sel = r;
        s.reg_val = val;
        s.gap_pct = 0;
        pending.insert(pending.size(), s);
        if (r == REG_VERTEX_COUNT)
            gen_n = (val[5:0] < 2) ? 2 : (val[5:0] > 32) ? 32 : int'(val[5:0]);
    endtask

    task automatic push_drain();
        step_t s;
        s.kind = STEP_DRAIN;
        s.cmd = CMD_LOAD;
        s.vidx = '0;
        s.cand = '0;
        s.nbr = '0;
        s.reg_sel = REG_VERTEX_COUNT;
        s.reg_val = '0;
        s.gap_pct = 0;
        pending.insert(pending.size(), s);
    endtask

    // small counts make ties and threshold hits common
    function automatic logic [31:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(15);
        if (r < 80) return $urandom;
        if (r < 90) return 32'hFFFF_FFFF;
        return 32'd0;
    endfunction

    task automatic shuffle(ref int perm[32], input int n);
        int j;
        int t;
        for (int i = 0; i < 32; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
    endtask

    task automatic link(ref logic [31:0] nbr[32], input int a, input int b);
        int t;
        t = $urandom_range(9);
        if (t != 9) nbr[a][b] = 1'b1;
        if (t != 8) nbr[b][a] = 1'b1;
    endtask

    // Optionally sets the counts, loads every query vertex, then requests a plan.
    task automatic plan_scenario(logic [5:0] vc_raw, bit set_vc);
        logic [31:0] nbr[32];
        logic [31:0] m;
        logic [63:0] wide;
        int          perm[32];
        int          n;
        int          style;
        int          cut;
        int          r;
        logic [31:0] dvc;
        if (set_vc)
            push_cfg(REG_VERTEX_COUNT, ($urandom & 32'hFFFF_FFC0) | {26'd0, vc_raw});
        if ($urandom_range(1) == 0)
        begin
            r = $urandom_range(99);
            dvc = (r < 35) ? 32'hFFFF_FFFF : (r < 55) ? 32'd0 :
                  (r < 90) ? $urandom_range(15) : $urandom;
            push_cfg(REG_DATA_VERTEX_COUNT, dvc);
        end
        n = gen_n;
        wide = (64'd1 << n) - 64'd1;
        m = wide[31:0];
        for (int v = 0; v < 32; v++)
            nbr[v] = ($urandom_range(3) == 0) ? ($urandom & ~m) : 32'd0;
        style = $urandom_range(99);
        if (style >= 70 && style < 85)
        begin
            for (int v = 0; v < n; v++) nbr[v] = $urandom;
        end
        else
        begin
            shuffle(perm, n);
            cut = (style >= 85) ? $urandom_range(n - 1, 1) : 0;
            for (int k = 1; k < n; k++)
                if (k != cut)
                    link(nbr, perm[k],
                         perm[(k > cut && cut > 0) ? $urandom_range(k - 1, cut)
                                                   : $urandom_range(k - 1)]);
            if (cut == 0)
                repeat ($urandom_range(n / 2))
                    link(nbr, $urandom_range(n - 1), $urandom_range(n - 1));
        end
        shuffle(perm, n);
        for (int k = 0; k < n; k++)
            push_load(perm[k], rand_count(), nbr[perm[k]]);
        if ($urandom_range(4) == 0)
            push_load($urandom_range(31), $urandom, $urandom);
        push_plan();
    endtask

    initial
    begin : main
        int  rand_base;
        int  r_items;
        int  scen;
        bit  big_done;
        int  r;

        // reset count 2: start vertex on fewest count, lone start gives disconnected
        push_load(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_load(1, 32'd0, 32'd0);
        push_plan();
        push_load(1, 32'd0, 32'h0000_0001);
        push_plan();
        // pivot seen only through the earlier vertex's mask
        push_load(0, 32'hFFFF_FFFF, 32'd0);
        push_plan();
        // equal counts: higher degree wins (self loop counts)
        push_load(0, 32'd7, 32'h0000_0002);
        push_load(1, 32'd7, 32'h0000_0003);
        push_plan();
        // full tie, mask bits above n ignored: lower index wins
        push_load(0, 32'd7, 32'hFFFF_FFFE);
        push_load(1, 32'd7, 32'h8000_0001);
        push_plan();
        push_drain();
        push_cfg(REG_DATA_VERTEX_COUNT, 32'd0);
        push_plan();
        push_load(1, 32'd0, 32'h0000_0001);
        push_plan();
        push_cfg(REG_DATA_VERTEX_COUNT, 32'd7);
        push_plan();
        push_cfg(REG_VERTEX_COUNT, 32'd3);
        push_load(0, 32'd5, 32'h0000_0006);
        push_load(1, 32'd5, 32'h0000_0004);
        push_load(2, 32'd5, 32'h0000_0001);
        push_plan();
        push_cfg(REG_DATA_VERTEX_COUNT, 32'hFFFF_FFFF);

        rand_base = stim_items;
        scen = 0;
        big_done = 0;
        while (stim_items < rand_base + 80)
        begin
            r_items = stim_items - rand_base;
            gen_pct = (r_items < 27) ? 19 : (r_items < 54) ? 64 : 0;
            if (scen == 0)
                plan_scenario(6'd0, 1'b1);
            else if (scen == 1)
                plan_scenario(6'd1, 1'b1);
            else if (scen == 2)
                plan_scenario(6'd63, 1'b1);
            else if (!big_done && r_items >= 45)
            begin
                plan_scenario(6'd32, 1'b1);
                big_done = 1;
            end
            else
            begin
                r = $urandom_range(99);
                plan_scenario((r < 80) ? 6'($urandom_range(8, 2)) :
                              (r < 90) ? 6'($urandom_range(16, 9)) :
                                         6'($urandom_range(1)),
                              $urandom_range(1));
            end
            // occasionally hold off until the planner has drained
            if (scen % 4 == 3)
                push_drain();
            scen++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending.size() != 0 || start || cfg_write_en || busy ||
               order_expect.size() != 0);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gmop_pkg.sv
rtl/gmop_ram.sv
rtl/greedy_match_order_planner_core.sv
verif/testbench.sv
